>>> hdl/pdc_pkg.sv
// Shared types and constants for the PWM period and duty capture core.
// Used by the controller, the datapath and the top level; no dependencies.
package pdc_pkg;

   localparam int TIME_BITS  = 16;
   localparam int DUTY_BITS  = 7;
   localparam int DUTY_SCALE = 100;

   localparam logic [DUTY_BITS-1:0] DUTY_MAX  = 7'd100;
   localparam logic [2:0]           STEP_LAST = 3'd6;

   localparam logic [TIME_BITS-1:0] RELOAD_RESET = 16'hFFFF;
   localparam logic                 REG_RELOAD   = 1'b0;

   localparam logic [1:0] PH_FIRST_RISE = 2'd0;
   localparam logic [1:0] PH_FALL       = 2'd1;
   localparam logic [1:0] PH_NEXT_RISE  = 2'd2;

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_UPDATE   = 6'b000010,
      ST_DIV_INIT = 6'b000100,
      ST_DIV_STEP = 6'b001000,
      ST_DIV_END  = 6'b010000,
      ST_FINISH   = 6'b100000
   } state_type;

   typedef struct packed {
      logic       capture;
      logic       update;
      logic       div_init;
      logic       div_step;
      logic       div_end;
      logic       load_out;
      logic [2:0] step_idx;
   } cmd_type;

   typedef struct packed {
      logic div_needed;
      logic div_sat;
   } status_type;

endpackage

>>> hdl/pdc_ctrl.sv
// Controller for the PWM capture core: sequences edge update, duty division
// and result hand-off. Depends on pdc_pkg.
module pdc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  pdc_pkg::status_type  status,
   output pdc_pkg::cmd_type     cmd
);

   pdc_pkg::state_type state_ff, state_in;
   logic [2:0]         step_ff, step_in;
   logic               rsp_valid_ff, rsp_valid_in;

   assign req_tready = (state_ff == pdc_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         pdc_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = pdc_pkg::ST_UPDATE;
            end
         end
         pdc_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = status.div_needed ? pdc_pkg::ST_DIV_INIT : pdc_pkg::ST_FINISH;
         end
         pdc_pkg::ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            step_in      = pdc_pkg::STEP_LAST;
            state_in     = status.div_sat ? pdc_pkg::ST_FINISH : pdc_pkg::ST_DIV_STEP;
         end
         pdc_pkg::ST_DIV_STEP: begin
            cmd.div_step = 1'b1;
            cmd.step_idx = step_ff;
            if (step_ff == 3'd0) begin
               state_in = pdc_pkg::ST_DIV_END;
            end else begin
               step_in = step_ff - 3'd1;
            end
         end
         pdc_pkg::ST_DIV_END: begin
            cmd.div_end = 1'b1;
            state_in    = pdc_pkg::ST_FINISH;
         end
         pdc_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = pdc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pdc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pdc_pkg::ST_IDLE;
         step_ff      <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef ASSERT_OFF
   a_accept_to_update: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pdc_pkg::ST_IDLE && req_tvalid) |=> (state_ff == pdc_pkg::ST_UPDATE))
      else $error("accepted beat did not move to update");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pdc_pkg::ST_DIV_STEP) |-> (step_ff <= pdc_pkg::STEP_LAST))
      else $error("divide step index out of range");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == pdc_pkg::ST_FINISH))
      else $error("result raised outside finish");
`endif

endmodule

>>> hdl/pdc_datapath.sv
// Datapath for the PWM capture core: edge timestamps, tick counts, the
// shift-subtract duty divider and the result register. Depends on pdc_pkg.
module pdc_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  pdc_pkg::cmd_type     cmd,
   output pdc_pkg::status_type  status,
   input  logic [15:0]          capture_time,
   input  logic [15:0]          reload_value,
   output logic [55:0]          rsp_tdata,
   output logic                 rsp_tuser
);

   localparam int COUNTER_BITS = pdc_pkg::TIME_BITS;
   localparam int NW = COUNTER_BITS + pdc_pkg::DUTY_BITS;

   function automatic logic [COUNTER_BITS-1:0] ticks_between(input logic [15:0] from_t,
                                                             input logic [15:0] to_t,
                                                             input logic [15:0] reload);
      logic [32:0] r;
      if (to_t >= from_t) begin
         r = {17'b0, to_t} - {17'b0, from_t};
      end else begin
         r = {17'b0, reload} + 33'd1 - {17'b0, from_t} + {17'b0, to_t};
      end
      return r[COUNTER_BITS-1:0];
   endfunction

   logic [15:0]              t_ff, t_in;
   logic [1:0]               phase_ff, phase_in;
   logic [15:0]              last_rise_ff, last_rise_in;
   logic [15:0]              last_fall_ff, last_fall_in;
   logic [COUNTER_BITS-1:0]  high_ff, high_in;
   logic [COUNTER_BITS-1:0]  low_ff, low_in;
   logic [COUNTER_BITS-1:0]  period_ff, period_in;
   logic [6:0]               duty_ff, duty_in;
   logic                     done_ff, done_in;
   logic [NW-1:0]            num_ff, num_in;
   logic [NW-1:0]            rem_ff, rem_in;
   logic [6:0]               quo_ff, quo_in;
   logic [55:0]              out_data_ff;
   logic                     out_user_ff;

   logic [COUNTER_BITS-1:0]  rise_ticks, fall_ticks;
   logic [NW-1:0]            divisor_sh;

   assign rise_ticks = ticks_between(last_rise_ff, t_ff, reload_value);
   assign fall_ticks = ticks_between(last_fall_ff, t_ff, reload_value);
   assign divisor_sh = NW'(period_ff) << cmd.step_idx;

   assign status.div_needed = (phase_ff == pdc_pkg::PH_NEXT_RISE) &&
                              (rise_ticks != '0);
   assign status.div_sat    = (num_ff >= {period_ff, 7'b0});

   always_comb begin
      t_in         = t_ff;
      phase_in     = phase_ff;
      last_rise_in = last_rise_ff;
      last_fall_in = last_fall_ff;
      high_in      = high_ff;
      low_in       = low_ff;
      period_in    = period_ff;
      duty_in      = duty_ff;
      done_in      = done_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      if (cmd.capture) begin
         t_in = capture_time;
      end
      if (cmd.update) begin
         case (phase_ff)
            pdc_pkg::PH_FALL: begin
               last_fall_in = t_ff;
               high_in      = rise_ticks;
               phase_in     = pdc_pkg::PH_NEXT_RISE;
               done_in      = 1'b0;
            end
            pdc_pkg::PH_NEXT_RISE: begin
               period_in    = rise_ticks;
               low_in       = fall_ticks;
               num_in       = NW'(high_ff) * NW'(pdc_pkg::DUTY_SCALE);
               last_rise_in = t_ff;
               phase_in     = pdc_pkg::PH_FALL;
               done_in      = 1'b1;
            end
            default: begin
               last_rise_in = t_ff;
               phase_in     = pdc_pkg::PH_FALL;
               done_in      = 1'b0;
            end
         endcase
      end
      if (cmd.div_init) begin
         if (status.div_sat) begin
            duty_in = pdc_pkg::DUTY_MAX;
         end else begin
            rem_in = num_ff;
            quo_in = 7'd0;
         end
      end
      // restoring step: quotient is known to fit in seven bits here
      if (cmd.div_step && (rem_ff >= divisor_sh)) begin
         rem_in = rem_ff - divisor_sh;
         quo_in = quo_ff | (7'd1 << cmd.step_idx);
      end
      if (cmd.div_end) begin
         duty_in = (quo_ff > pdc_pkg::DUTY_MAX) ? pdc_pkg::DUTY_MAX : quo_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= pdc_pkg::PH_FIRST_RISE;
         last_rise_ff <= '0;
         last_fall_ff <= '0;
         high_ff      <= '0;
         low_ff       <= '0;
         period_ff    <= '0;
         duty_ff      <= '0;
         done_ff      <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         last_rise_ff <= last_rise_in;
         last_fall_ff <= last_fall_in;
         high_ff      <= high_in;
         low_ff       <= low_in;
         period_ff    <= period_in;
         duty_ff      <= duty_in;
         done_ff      <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff   <= t_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (cmd.load_out) begin
         out_data_ff <= {(phase_ff == pdc_pkg::PH_FALL), duty_ff, period_ff,
                         low_ff, high_ff};
         out_user_ff <= done_ff;
      end
   end

   assign rsp_tdata = out_data_ff;
   assign rsp_tuser = out_user_ff;

endmodule

>>> hdl/pwm_period_duty_capture_core.sv
// PWM input-capture core: one capture timestamp per req beat, one result
// per beat with high, low and period ticks and the duty in percent. Each
// item takes an edge update; when a nonzero period completes, the duty is
// set to 100 at once if it saturates, else it comes from a shift-subtract
// divider that resolves one quotient bit per cycle, seven bits in all. A
// finished result stays in the rsp register while the next beat is taken;
// the core waits before loading another only if that result has not been
// taken yet. The reload register (byte address 0) sets the timer wrap used
// for elapsed ticks and should be written while no beat is in flight.
// Depends on pdc_pkg, pdc_ctrl and pdc_datapath.
module pwm_period_duty_capture_core (
   input  logic        clock,
   input  logic        reset,
   // req
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] capture_time
   // rsp
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [15:0] high_time, [31:16] low_time,
                                    // [47:32] period_len, [54:48] duty_pct,
                                    // [55] arm_falling
   output logic        rsp_tuser,   // [0] period_done
   // csr
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   pdc_pkg::cmd_type    cmd;
   pdc_pkg::status_type status;

   logic [15:0] reload_ff, reload_in;
   logic        reload_sel;

   assign csr_pready = 1'b1;
   assign reload_sel = (csr_paddr[2] == pdc_pkg::REG_RELOAD);

   always_comb begin
      reload_in = reload_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && reload_sel) begin
         reload_in = csr_pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reload_ff <= pdc_pkg::RELOAD_RESET;
      end else begin
         reload_ff <= reload_in;
      end
   end

   assign csr_prdata = reload_sel ? {16'b0, reload_ff} : 32'b0;

   pdc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pdc_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .capture_time (req_tdata),
      .reload_value (reload_ff),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser)
   );

endmodule

>>> tb/tb_top.sv
// Self-checking bench for pwm_period_duty_capture_core: capture timestamps in,
// period/high/low/duty results out, checked against an in-bench predictor.
// Depends on pdc_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_top;

   localparam int IDLE_LIMIT  = 4000;
   localparam int DRAIN_WAIT  = 20;
   localparam int PHASE_ITEMS = 130;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct {
      logic [15:0] high_time;
      logic [15:0] low_time;
      logic [15:0] period_len;
      logic [6:0]  duty_pct;
      logic        arm_falling;
      logic        period_done;
   } measurement_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;    // [15:0] capture_time
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;         // [15:0] high, [31:16] low, [47:32] period,
                                   // [54:48] duty, [55] arm_falling
   logic        rsp_tuser;         // [0] period_done
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   logic [15:0]     capture_q[$];
   measurement_type measurement_q[$];
   idle_mode_type   idle_mode = IDLE_NONE;
   int              error_count = 0;
   int              quiet_cycles = 0;

   // predictor state
   logic [15:0] reload_reg = pdc_pkg::RELOAD_RESET;
   logic [1:0]  edge_phase = pdc_pkg::PH_FIRST_RISE;
   logic [15:0] rise_stamp = '0;
   logic [15:0] fall_stamp = '0;
   logic [15:0] high_reg = '0;
   logic [15:0] low_reg = '0;
   logic [15:0] period_reg = '0;
   logic [6:0]  duty_reg = '0;

   pwm_period_duty_capture_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   // wrapped elapsed time, modulo reload+1, truncated to the counter width
   function automatic logic [15:0] elapsed_ticks(logic [15:0] from_t, logic [15:0] to_t);
      longint unsigned d;
      if (to_t >= from_t) begin
         d = longint'(to_t) - longint'(from_t);
      end else begin
         d = (longint'(reload_reg) + 1) - longint'(from_t) + longint'(to_t);
      end
      return d[15:0];
   endfunction

   function automatic measurement_type measure_edge(logic [15:0] stamp);
      measurement_type m;
      longint unsigned q;
      logic done;
      done = 1'b0;
      if (edge_phase == pdc_pkg::PH_FALL) begin
         fall_stamp = stamp;
         high_reg   = elapsed_ticks(rise_stamp, stamp);
         edge_phase = pdc_pkg::PH_NEXT_RISE;
      end else if (edge_phase == pdc_pkg::PH_NEXT_RISE) begin
         period_reg = elapsed_ticks(rise_stamp, stamp);
         low_reg    = elapsed_ticks(fall_stamp, stamp);
         if (period_reg != 0) begin
            q = (longint'(high_reg) * pdc_pkg::DUTY_SCALE) / longint'(period_reg);
            duty_reg = (q > pdc_pkg::DUTY_SCALE) ? pdc_pkg::DUTY_MAX : q[6:0];
         end
         rise_stamp = stamp;
         edge_phase = pdc_pkg::PH_FALL;
         done = 1'b1;
      end else begin
         rise_stamp = stamp;
         edge_phase = pdc_pkg::PH_FALL;
      end
      m.high_time   = high_reg;
      m.low_time    = low_reg;
      m.period_len  = period_reg;
      m.duty_pct    = duty_reg;
      m.arm_falling = (edge_phase == pdc_pkg::PH_FALL);
      m.period_done = done;
      return m;
   endfunction

   function automatic bit sender_holds();
      if (idle_mode == IDLE_SENDER) return $urandom_range(0, 99) < 46;
      if (idle_mode == IDLE_BOTH) return $urandom_range(0, 99) < 30;
      return 1'b0;
   endfunction

   function automatic bit receiver_stalls();
      if (idle_mode == IDLE_RECEIVER) return $urandom_range(0, 99) < 46;
      if (idle_mode == IDLE_BOTH) return $urandom_range(0, 99) < 30;
      return 1'b0;
   endfunction

   task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
      $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   // req driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            measurement_q.push_back(measure_edge(req_tdata));
         end
         if (!req_tvalid || req_tready) begin
            if (capture_q.size() > 0 && !sender_holds()) begin
               req_tdata  <= capture_q.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // rsp monitor
   always @(posedge clock) begin
      measurement_type m;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (measurement_q.size() == 0) begin
               report_mismatch("unexpected rsp beat, tdata low", 64'(rsp_tdata[31:0]), 64'd0);
            end else begin
               m = measurement_q.pop_front();
               if (rsp_tdata[15:0] !== m.high_time)
                  report_mismatch("high_time", 64'(rsp_tdata[15:0]), 64'(m.high_time));
               if (rsp_tdata[31:16] !== m.low_time)
                  report_mismatch("low_time", 64'(rsp_tdata[31:16]), 64'(m.low_time));
               if (rsp_tdata[47:32] !== m.period_len)
                  report_mismatch("period_len", 64'(rsp_tdata[47:32]), 64'(m.period_len));
               if (rsp_tdata[54:48] !== m.duty_pct)
                  report_mismatch("duty_pct", 64'(rsp_tdata[54:48]), 64'(m.duty_pct));
               if (rsp_tdata[55] !== m.arm_falling)
                  report_mismatch("arm_falling", 64'(rsp_tdata[55]), 64'(m.arm_falling));
               if (rsp_tuser !== m.period_done)
                  report_mismatch("period_done", 64'(rsp_tuser), 64'(m.period_done));
            end
         end
         rsp_tready <= !receiver_stalls();
      end
   end

   // watchdog: cycles without any beat
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("FAIL pwm_period_duty_capture_core");
            $finish;
         end
      end
   end

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (addr == {pdc_pkg::REG_RELOAD, 2'b00}) reload_reg = data[15:0];
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (capture_q.size() > 0 || measurement_q.size() > 0 || req_tvalid)
         @(negedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   function automatic logic [15:0] random_capture(logic [15:0] prev);
      int unsigned pick;
      int unsigned span;
      pick = $urandom_range(0, 9);
      span = int'(reload_reg) + 1;
      if (pick < 6) begin
         // plausible waveform: step forward from the last edge and wrap
         return 16'((int'(prev) + $urandom_range(0, span > 4 ? span / 2 : span)) % span);
      end else if (pick < 9) begin
         return 16'($urandom_range(0, int'(reload_reg)));
      end
      return 16'($urandom_range(0, 65535));
   endfunction

   initial begin
      logic [15:0] directed[$];
      logic [15:0] reloads[8];
      logic [15:0] prev;
      directed = '{100, 150, 200, 200, 200, 65535, 10, 5, 6, 1000, 900, 1100,
                   0, 65535, 65535, 0, 0, 0, 12345, 43210, 21845, 43690};
      reloads = '{16'hFFFF, 16'd0, 16'd1, 16'd99, 16'($urandom_range(2, 65534)),
                  16'd255, 16'hFFFF, 16'($urandom_range(100, 5000))};
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      csr_write({pdc_pkg::REG_RELOAD, 2'b00}, 32'(pdc_pkg::RELOAD_RESET));
      foreach (directed[i]) capture_q.push_back(directed[i]);
      wait_drained();

      prev = '0;
      for (int ph = 0; ph < 8; ph++) begin
         csr_write({pdc_pkg::REG_RELOAD, 2'b00}, {16'h0000, reloads[ph]});
         idle_mode = idle_mode_type'(ph % 4);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            prev = random_capture(prev);
            capture_q.push_back(prev);
         end
         wait_drained();
      end

      if (error_count == 0) begin
         $display("PASS pwm_period_duty_capture_core");
      end else begin
         $display("FAIL pwm_period_duty_capture_core");
      end
      $finish;
   end

endmodule

>>> files.f
hdl/pdc_pkg.sv
hdl/pdc_ctrl.sv
hdl/pdc_datapath.sv
hdl/pwm_period_duty_capture_core.sv
tb/tb_top.sv
